// ----- src/ptsb_pkg.sv -----
`default_nettype none

package ptsb_pkg;

  // Field widths of the item channels
  localparam int ACT_W  = 2;
  localparam int PER_W  = 16;
  localparam int ID_W   = 4;
  localparam int KIND_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_REG    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REG     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_init;
    logic scan_run;
    logic flush;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_tick;
    logic out_free;
    logic pend_v;
    logic scan_done;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/ptsb_if.sv -----
`default_nettype none

interface ptsb_in_if import ptsb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [PER_W-1:0] period;
  logic [ID_W-1:0]  slot_id;

  modport source (output valid, output action, output period, output slot_id, input ready);
  modport sink   (input valid, input action, input period, input slot_id, output ready);
endinterface

interface ptsb_out_if import ptsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   slot_number;
  logic              last;

  modport source (output valid, output kind, output slot_number, output last, input ready);
  modport sink   (input valid, input kind, input slot_number, input last, output ready);
endinterface

`default_nettype wire

// ----- src/ptsb_ram.sv -----
`default_nettype none

module ptsb_ram #(
  parameter int W = 32,
  parameter int D = 8,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/ptsb_ctrl.sv -----
`default_nettype none

module ptsb_ctrl import ptsb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire stat_t stat,
  output logic       in_ready,
  output ctl_t       ctl
);

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.in_tick ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v || stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready      = 1'b0;
    ctl           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        ctl.load      = in_valid;
        ctl.scan_init = in_valid && stat.in_tick;
      end
      S_EXEC: begin
        ctl.exec = stat.out_free;
      end
      S_SCAN: begin
        ctl.scan_run = 1'b1;
      end
      S_FLUSH: begin
        ctl.flush = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/ptsb_dp.sv -----
`default_nettype none

module ptsb_dp import ptsb_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_t              ctl,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [PER_W-1:0]  in_period,
  input  wire logic [ID_W-1:0]   in_slot_id,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic      [KIND_W-1:0] out_kind,
  output logic      [ID_W-1:0]   out_slot_number,
  output logic                   out_last,
  output stat_t                  stat
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = 2 * PER_W;
  localparam logic [CW-1:0] END_C = CW'(SLOTS);

  // Latched item
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [PER_W-1:0] per_r, per_nxt;
  logic [ID_W-1:0]  sid_r, sid_nxt;

  // Per-slot flags
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [SLOTS-1:0] cvalid_r, cvalid_nxt;

  // Scan pipeline
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;
  logic          vld_r, vld_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [ID_W-1:0] pend_id_r, pend_id_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  // Slot memory: period in the upper half, count in the lower
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic [SLOTS-1:0] free_v, low_v;
  logic [IW-1:0]    free_idx;
  logic             full;
  logic             rm_ok;
  logic [IW-1:0]    rm_idx;
  logic [PER_W-1:0] cnt_cur, cnt_inc, per_cur;
  logic             fire, stall, more, out_free, exec_reg;

  ptsb_ram #(.W(RW), .D(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Lowest free slot
  always_comb begin
    free_v   = ~active_r;
    low_v    = free_v & (~free_v + SLOTS'(1));
    full     = ~|free_v;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (low_v[i]) begin
        free_idx = free_idx | IW'(i);
      end
    end
  end

  // Remove target
  assign rm_ok  = (sid_r != '0) && (32'(sid_r) <= SLOTS);
  assign rm_idx = IW'(32'(sid_r) - 32'd1);

  // Advance the count of the slot under scan, saturating
  assign cnt_cur  = cvalid_r[p_idx_r] ? ram_rdata[PER_W-1:0] : '0;
  assign per_cur  = ram_rdata[RW-1:PER_W];
  assign cnt_inc  = (cnt_cur == '1) ? cnt_cur : cnt_cur + PER_W'(1);
  assign fire     = vld_r && active_r[p_idx_r] && (cnt_inc >= per_cur);
  assign out_free = !out_valid_r || out_ready;
  assign stall    = ctl.scan_run && fire && pend_v_r && !out_free;
  assign more     = rd_idx_r != END_C;
  assign exec_reg = ctl.exec && (act_r == ACT_REG) && !full;

  // Memory ports
  assign ram_re    = ctl.scan_run && !stall && more;
  assign ram_raddr = rd_idx_r[IW-1:0];
  assign ram_we    = exec_reg || (ctl.scan_run && vld_r && !stall);
  assign ram_waddr = exec_reg ? free_idx : p_idx_r;
  assign ram_wdata = exec_reg ? {per_r, PER_W'(0)}
                              : {per_cur, (fire ? PER_W'(0) : cnt_inc)};

  // Next values
  always_comb begin
    act_nxt       = act_r;
    per_nxt       = per_r;
    sid_nxt       = sid_r;
    active_nxt    = active_r;
    cvalid_nxt    = cvalid_r;
    rd_idx_nxt    = rd_idx_r;
    p_idx_nxt     = p_idx_r;
    vld_nxt       = vld_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;

    // Take the item
    if (ctl.load) begin
      act_nxt = in_action;
      per_nxt = in_period;
      sid_nxt = in_slot_id;
    end

    if (ctl.scan_init) begin
      rd_idx_nxt = '0;
      vld_nxt    = 1'b0;
      pend_v_nxt = 1'b0;
    end

    // Register or remove
    if (ctl.exec) begin
      case (act_r)
        ACT_REG: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (full) begin
            out_kind_nxt = KIND_FULL;
            out_id_nxt   = '0;
          end else begin
            active_nxt[free_idx] = 1'b1;
            cvalid_nxt[free_idx] = 1'b1;
            out_kind_nxt = KIND_REG;
            out_id_nxt   = ID_W'(32'(free_idx) + 32'd1);
          end
        end
        ACT_REMOVE: begin
          if (rm_ok) begin
            active_nxt[rm_idx] = 1'b0;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REMOVED;
            out_id_nxt    = sid_r;
            out_last_nxt  = 1'b1;
          end
        end
        default: begin
          out_last_nxt = out_last_r;
        end
      endcase
    end

    // Walk the slots, one read issued and one slot retired per cycle unless stalled
    if (ctl.scan_run && !stall) begin
      if (more) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
        p_idx_nxt  = rd_idx_r[IW-1:0];
        vld_nxt    = 1'b1;
      end else begin
        vld_nxt = 1'b0;
      end
      if (vld_r) begin
        cvalid_nxt[p_idx_r] = 1'b1;
        if (fire) begin
          // Hand on the held fire, keep the new one until we know it is not last
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FIRED;
            out_id_nxt    = pend_id_r;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = ID_W'(32'(p_idx_r) + 32'd1);
        end
      end
    end

    // Drop the held fire as the last result
    if (ctl.flush && pend_v_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_FIRED;
      out_id_nxt    = pend_id_r;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      cvalid_r    <= '0;
      rd_idx_r    <= '0;
      vld_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cvalid_r    <= cvalid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      vld_r       <= vld_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    per_r      <= per_nxt;
    sid_r      <= sid_nxt;
    p_idx_r    <= p_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_slot_number = out_id_r;
  assign out_last        = out_last_r;

  assign stat.in_tick   = in_action == ACT_TICK;
  assign stat.out_free  = out_free;
  assign stat.pend_v    = pend_v_r;
  assign stat.scan_done = !vld_r && !more;

endmodule

`default_nettype wire

// ----- src/periodic_timer_slot_bank_top.sv -----
`default_nettype none

// Periodic timer slot bank: SLOTS slots with IDs 1..SLOTS, each with an active flag (a register),
// a 16-bit period and a saturating 16-bit tick count (both held in one small memory).
// Register (action 0) claims the lowest free slot and returns its ID, or table
// full; remove (action 1) frees an in-range ID and echoes it, other IDs give
// nothing; action 3 gives nothing. A tick (action 2) advances every count and
// emits one fire result per due active slot, in ID order, the final one with
// last set. Register and remove pass through an execute state that waits while
// a waiting result keeps the output register full. A tick scans the slots, which
// reads and writes back one slot per cycle, except while the result side stalls,
// through the single read port of the slot memory. One finished result may wait
// in the output register while the next item is taken. No clearing pass is
// needed after reset.
module periodic_timer_slot_bank_top import ptsb_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ptsb_in_if.sink     in_ch,
  ptsb_out_if.source  out_ch
);

  ctl_t  ctl;
  stat_t stat;

  ptsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .ctl      (ctl)
  );

  ptsb_dp #(.SLOTS(SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_action       (in_ch.action),
    .in_period       (in_ch.period),
    .in_slot_id      (in_ch.slot_id),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_slot_number (out_ch.slot_number),
    .out_last        (out_ch.last),
    .stat            (stat)
  );

  // No held fire survives into idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.pend_v)
    else $error("held fire result left behind after scan");

  // The final fire goes out and the block returns to idle in the same step
  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.flush && stat.pend_v && stat.out_free) |=>
      (in_ch.ready && out_ch.valid && out_ch.last && out_ch.kind == KIND_FIRED))
    else $error("last fire result not delivered on flush");

  // A scan never starts while the previous one still holds a fire
  a_scan_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan_init |=> !stat.pend_v)
    else $error("scan started with a stale held fire");

endmodule

`default_nettype wire

// ----- tb/ptsb_scoreboard.sv -----
`timescale 1ns / 1ps

// Watch both channels, keep a shadow of the slot bank and compare every result
// against the oldest outstanding prediction.
module ptsb_scoreboard import ptsb_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic clk,
  input  logic rst_n,
  ptsb_in_if   in_ch,
  ptsb_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   slot_number;
    logic              last;
  } slot_result_t;

  // Shadow slot state
  logic             slot_live  [SLOTS];
  logic [PER_W-1:0] slot_span  [SLOTS];
  logic [PER_W-1:0] slot_ticks [SLOTS];

  slot_result_t expected_results [$];

  task automatic push_result(input logic [KIND_W-1:0] kind, input int id, input logic last);
    slot_result_t r;
    r.kind        = kind;
    r.slot_number = ID_W'(id);
    r.last        = last;
    expected_results.push_back(r);
  endtask

  // Apply one accepted item to the shadow state and queue what it must produce
  task automatic model_action(input logic [ACT_W-1:0] act, input logic [PER_W-1:0] per,
                              input logic [ID_W-1:0] id);
    int fired;
    bit claimed;
    fired   = 0;
    claimed = 1'b0;
    case (act)
      ACT_REG: begin
        // claim the lowest free slot, or report the table full
        for (int i = 0; i < SLOTS; i++) begin
          if (!claimed && !slot_live[i]) begin
            slot_live[i]  = 1'b1;
            slot_span[i]  = per;
            slot_ticks[i] = '0;
            claimed       = 1'b1;
            push_result(KIND_REG, i + 1, 1'b1);
          end
        end
        if (!claimed) push_result(KIND_FULL, 0, 1'b1);
      end
      ACT_REMOVE: begin
        // out-of-range IDs are dropped silently
        if (id >= 1 && id <= SLOTS) begin
          slot_live[id - 1] = 1'b0;
          push_result(KIND_REMOVED, id, 1'b1);
        end
      end
      ACT_TICK: begin
        // advance every count, saturating, then fire due slots in ID order
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_ticks[i] != '1) slot_ticks[i] = slot_ticks[i] + 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && slot_ticks[i] >= slot_span[i]) begin
            slot_ticks[i] = '0;
            push_result(KIND_FIRED, i + 1, 1'b0);
            fired++;
          end
        end
        if (fired > 0) expected_results[expected_results.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare results before predicting, so a same-edge item never pairs with its own result
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        slot_span[i]  = '0;
        slot_ticks[i] = '0;
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d, slot_number %0d, last %0d",
                 out_ch.kind, out_ch.slot_number, out_ch.last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("slot_number", want.slot_number, out_ch.slot_number);
          check_field("last", want.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) model_action(in_ch.action, in_ch.period, in_ch.slot_id);
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb import ptsb_pkg::*; ();

  localparam int SLOTS = 8;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 203;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   steady = 1'b0;
  int   fail_count;
  int   pending;

  ptsb_in_if  in_ch();
  ptsb_out_if out_ch();

  periodic_timer_slot_bank_top #(.SLOTS(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ptsb_scoreboard #(.SLOTS(SLOTS)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones; none while in a steady stretch
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [PER_W-1:0] per,
                           input logic [ID_W-1:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action  = act;
    in_ch.period  = per;
    in_ch.slot_id = id;
    in_ch.valid   = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: stall at random
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int n;
    int r;
    logic [ACT_W-1:0] act;
    logic [PER_W-1:0] per;
    logic [ID_W-1:0]  id;

    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_REG;
    in_ch.period  = '0;
    in_ch.slot_id = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Fill the table with a spread of periods, then overflow it
    send_item(ACT_REG, 16'd0, '0);
    send_item(ACT_REG, 16'd1, '0);
    send_item(ACT_REG, 16'd2, '0);
    send_item(ACT_REG, 16'd3, '0);
    send_item(ACT_REG, 16'hFFFF, '0);
    send_item(ACT_REG, 16'h8000, '0);
    send_item(ACT_REG, 16'd5, '0);
    send_item(ACT_REG, 16'd1, '0);
    send_item(ACT_REG, 16'd7, '1);
    // Several slots due on one tick
    repeat (3) send_item(ACT_TICK, '0, '0);
    // Out-of-range removes, a double remove, the spare action code
    send_item(ACT_REMOVE, '0, 4'd0);
    send_item(ACT_REMOVE, '0, 4'd9);
    send_item(ACT_REMOVE, '1, 4'd15);
    send_item(ACT_REMOVE, '0, 4'd3);
    send_item(ACT_REMOVE, '0, 4'd3);
    send_item(ACT_SPARE, '1, '1);
    // Re-claim the freed slot with period zero
    send_item(ACT_REG, 16'd0, '0);
    send_item(ACT_TICK, '1, '1);
    // Leave only slots with huge periods, so the tick produces nothing
    send_item(ACT_REMOVE, '0, 4'd1);
    send_item(ACT_REMOVE, '0, 4'd2);
    send_item(ACT_REMOVE, '0, 4'd3);
    send_item(ACT_REMOVE, '0, 4'd4);
    send_item(ACT_REMOVE, '0, 4'd7);
    send_item(ACT_REMOVE, '0, 4'd8);
    send_item(ACT_TICK, '0, '0);

    // Random mix, weighted towards short periods so slots fire often
    n = 0;
    while (n < RANDOM_ITEMS) begin
      steady = ((n / 40) % 3 == 2);
      per = $urandom();
      id  = $urandom();
      r   = $urandom_range(0, 99);
      if (r < 28) begin
        act = ACT_REG;
        r = $urandom_range(0, 9);
        if (r < 7) per = $urandom_range(0, 6);
        else if (r < 9) per = $urandom_range(0, 40);
      end else if (r < 48) begin
        act = ACT_REMOVE;
        if ($urandom_range(0, 99) < 85) id = $urandom_range(1, SLOTS);
      end else if (r < 95) begin
        act = ACT_TICK;
      end else begin
        act = ACT_SPARE;
      end
      send_item(act, per, id);
      n++;
    end
    in_ch.valid = 1'b0;
    steady = 1'b0;

    // Drain, then keep waiting for any stray results
    while (pending != 0) @(negedge clk);
    repeat (2 * SLOTS + 8) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
